// File: hw/rtl/utf8_validate_and_count_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 validator assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATE_AND_COUNT_ASSERT_SVH
`define UTF8_VALIDATE_AND_COUNT_ASSERT_SVH

`ifndef SYNTH
// Check a property outside reset
`define U8VC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("u8vc assertion failed");
// Check a property at every edge, reset included
`define U8VC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("u8vc assertion failed");
`else
`define U8VC_ASSERT(lbl, clk, rst_n, prop)
`define U8VC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hw/rtl/u8vc_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 validator package
// Shared widths, codes, item types and the saturating count helper.
// ----------------------------------------------------------------------------
`default_nettype none

package u8vc_pkg;

  localparam int unsigned CNT_W = 31;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Item kind codes
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Default continuation byte window
  localparam logic [7:0] CONT_LO = 8'h80;
  localparam logic [7:0] CONT_HI = 8'hBF;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic             malformed;
    logic [CNT_W-1:0] code_points;
    logic [CNT_W-1:0] utf16_units;
  } result_t;

  // Lead byte classification
  typedef struct packed {
    logic [1:0] pend;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       four;
    logic       bad;
    logic       single;
  } lead_t;

  // Add a small increment, clamp at the top of the count range
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                input logic [1:0]       inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, cnt} + {{(CNT_W-1){1'b0}}, inc};
    return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/u8vc_if.sv
// ----------------------------------------------------------------------------
// UTF-8 validator channels
// Valid/ready interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8vc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface u8vc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        malformed;
  logic [u8vc_pkg::CNT_W-1:0]  code_points;
  logic [u8vc_pkg::CNT_W-1:0]  utf16_units;

  modport source (output valid, output malformed, output code_points,
                  output utf16_units, input ready);
  modport sink   (input valid, input malformed, input code_points,
                  input utf16_units, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/u8vc_lead_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 lead byte decoder
// Maps a lead byte to its continuation count and first continuation window.
// ----------------------------------------------------------------------------
`default_nettype none

module u8vc_lead_decode (
  input  logic [7:0]      data_byte,
  output u8vc_pkg::lead_t lead
);
  import u8vc_pkg::*;

  // Classify the lead byte; E0/ED/F0/F4 narrow the next byte's window
  always_comb begin
    lead.pend   = 2'd0;
    lead.lo     = CONT_LO;
    lead.hi     = CONT_HI;
    lead.four   = 1'b0;
    lead.bad    = 1'b0;
    lead.single = 1'b0;
    unique case (data_byte) inside
      [8'h00:8'h7F]: begin
        lead.single = 1'b1;
      end
      [8'hC2:8'hDF]: begin
        lead.pend = 2'd1;
      end
      8'hE0: begin
        lead.pend = 2'd2;
        lead.lo   = 8'hA0;
      end
      8'hED: begin
        lead.pend = 2'd2;
        lead.hi   = 8'h9F;
      end
      [8'hE1:8'hEC], [8'hEE:8'hEF]: begin
        lead.pend = 2'd2;
      end
      8'hF0: begin
        lead.pend = 2'd3;
        lead.four = 1'b1;
        lead.lo   = 8'h90;
      end
      [8'hF1:8'hF3]: begin
        lead.pend = 2'd3;
        lead.four = 1'b1;
      end
      8'hF4: begin
        lead.pend = 2'd3;
        lead.four = 1'b1;
        lead.hi   = 8'h8F;
      end
      default: begin
        lead.bad = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/u8vc_scan.sv
// ----------------------------------------------------------------------------
// UTF-8 scan state
// Running well-formedness state and saturating counts, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module u8vc_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  u8vc_pkg::item_t   item,
  output u8vc_pkg::result_t res
);
  import u8vc_pkg::*;
  `include "utf8_validate_and_count_assert.svh"

  logic [1:0]       pend_r, pend_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic             four_r, four_nxt;
  logic             err_r, err_nxt;
  logic [CNT_W-1:0] pts_r, pts_nxt;
  logic [CNT_W-1:0] units_r, units_nxt;
  lead_t            lead;
  logic             finish;
  logic             fin_four;
  logic [1:0]       pend_dec;

  u8vc_lead_decode u_lead (
    .data_byte (item.data_byte),
    .lead      (lead)
  );

  assign pend_dec = pend_r - 2'd1;

  // Advance the byte state; clear it on an end item
  always_comb begin
    pend_nxt  = pend_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    four_nxt  = four_r;
    err_nxt   = err_r;
    finish    = 1'b0;
    fin_four  = four_r;
    if (item.kind == KIND_END) begin
      pend_nxt = 2'd0;
      lo_nxt   = CONT_LO;
      hi_nxt   = CONT_HI;
      four_nxt = 1'b0;
      err_nxt  = 1'b0;
    end else if (!err_r) begin
      if (pend_r != 2'd0) begin
        if (item.data_byte < lo_r || item.data_byte > hi_r) begin
          err_nxt = 1'b1;
        end else begin
          lo_nxt   = CONT_LO;
          hi_nxt   = CONT_HI;
          pend_nxt = pend_dec;
          if (pend_dec == 2'd0) begin
            finish   = 1'b1;
            four_nxt = 1'b0;
          end
        end
      end else begin
        lo_nxt   = lead.lo;
        hi_nxt   = lead.hi;
        four_nxt = lead.four;
        pend_nxt = lead.pend;
        err_nxt  = lead.bad;
        finish   = lead.single;
        fin_four = 1'b0;
      end
    end
  end

  // Count completed code points and their UTF-16 units
  always_comb begin
    pts_nxt   = pts_r;
    units_nxt = units_r;
    if (item.kind == KIND_END) begin
      pts_nxt   = '0;
      units_nxt = '0;
    end else if (finish) begin
      pts_nxt   = sat_add(pts_r, 2'd1);
      units_nxt = sat_add(units_r, fin_four ? 2'd2 : 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 2'd0;
      lo_r    <= CONT_LO;
      hi_r    <= CONT_HI;
      four_r  <= 1'b0;
      err_r   <= 1'b0;
      pts_r   <= '0;
      units_r <= '0;
    end else if (step) begin
      pend_r  <= pend_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      four_r  <= four_nxt;
      err_r   <= err_nxt;
      pts_r   <= pts_nxt;
      units_r <= units_nxt;
    end
  end

  // Report the string as it stands before the end item clears it
  always_comb begin
    res.malformed   = err_r || (pend_r != 2'd0);
    res.code_points = res.malformed ? '0 : pts_r;
    res.utf16_units = res.malformed ? '0 : units_r;
  end

  `U8VC_ASSERT(a_idle_window, clk, rst_n, (pend_r == 2'd0) |-> (lo_r == CONT_LO && hi_r == CONT_HI))
  `U8VC_ASSERT(a_four_pending, clk, rst_n, four_r |-> (pend_r != 2'd0))
  `U8VC_ASSERT(a_units_ge_points, clk, rst_n, units_r >= pts_r)

endmodule

`default_nettype wire

// File: hw/rtl/utf8_validate_and_count.sv
// ----------------------------------------------------------------------------
// UTF-8 validator with code point and UTF-16 length count
// Top level: input register, scan state and result register.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per transfer: kind = 0 with a string byte in
//   data_byte, or kind = 1 to close the string (data_byte ignored).
//   out_ch carries one result per end item: malformed, code_points and
//   utf16_units; both counts are zero when malformed is set and saturate
//   at 2^31-1 otherwise.
//   An end item passes the input register, then the result register, before
//   its result shows on out_ch. Throughput is one item per cycle while no end
//   item waits, set by the single register stage ahead of the scan state.
//   Data bytes never wait on out_ch. An end item waits in the input register
//   while a previous result is still held; in_ch.ready then drops until the
//   result transfers. Results hold steady while out_ch.ready is low.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   scan state to an empty string.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_validate_and_count (
  input  logic       clk,
  input  logic       rst_n,
  u8vc_in_if.sink    in_ch,
  u8vc_out_if.source out_ch
);
  import u8vc_pkg::*;
  `include "utf8_validate_and_count_assert.svh"

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t scan_res;
  logic    out_free;
  logic    s1_adv;
  logic    in_xfer;
  logic    out_load;

  // Handshake control
  assign out_free      = !out_valid_r || out_ch.ready;
  assign s1_adv        = s1_valid_r && (s1_item_r.kind == KIND_DATA || out_free);
  assign in_ch.ready   = !s1_valid_r || s1_adv;
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_load      = s1_adv && (s1_item_r.kind == KIND_END);
  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input item on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.kind      <= in_ch.kind;
      s1_item_r.data_byte <= in_ch.data_byte;
    end
  end

  u8vc_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .item  (s1_item_r),
    .res   (scan_res)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= scan_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.malformed   = out_res_r.malformed;
  assign out_ch.code_points = out_res_r.code_points;
  assign out_ch.utf16_units = out_res_r.utf16_units;

  `U8VC_ASSERT(a_load_slot_free, clk, rst_n, out_load |-> (!out_valid_r || out_ch.ready))
  `U8VC_ASSERT(a_load_shows, clk, rst_n, out_load |=> out_valid_r)
  `U8VC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!out_valid_r && !s1_valid_r))

endmodule

`default_nettype wire

// File: tb/utf8_validate_and_count_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 validator scoreboard
// Watches both channels, predicts the end-of-string report from the bytes
// seen on the input and compares every report that leaves the block.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_validate_and_count_checker (
  input  logic clk,
  input  logic rst_n,
  u8vc_in_if   in_mon,
  u8vc_out_if  out_mon,
  output int   mismatch_total,
  output int   reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import u8vc_pkg::*;

  // Predicted scan state of the current string
  logic [1:0]       conts_left;
  logic [7:0]       low_bound;
  logic [7:0]       high_bound;
  logic             four_byte;
  logic             bad_string;
  logic [CNT_W-1:0] point_total;
  logic [CNT_W-1:0] unit_total;

  // Reports predicted but not yet seen on the output
  result_t string_reports[$];

  // Add with clamp at the top of the count range
  function automatic logic [CNT_W-1:0] clamp_add(input logic [CNT_W-1:0] cnt,
                                                 input int unsigned inc);
    longint unsigned sum;
    sum = longint'(cnt) + inc;
    return (sum > longint'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

  task automatic clear_scan();
    conts_left  = 2'd0;
    low_bound   = CONT_LO;
    high_bound  = CONT_HI;
    four_byte   = 1'b0;
    bad_string  = 1'b0;
    point_total = '0;
    unit_total  = '0;
  endtask

  task automatic count_point();
    point_total = clamp_add(point_total, 1);
    unit_total  = clamp_add(unit_total, four_byte ? 2 : 1);
    four_byte   = 1'b0;
  endtask

  // Advance the scan state by one string byte
  task automatic scan_byte(input logic [7:0] b);
    if (bad_string) begin
      return;
    end
    if (conts_left != 2'd0) begin
      if (b < low_bound || b > high_bound) begin
        bad_string = 1'b1;
        return;
      end
      low_bound  = CONT_LO;
      high_bound = CONT_HI;
      conts_left = conts_left - 2'd1;
      if (conts_left == 2'd0) begin
        count_point();
      end
      return;
    end
    low_bound  = CONT_LO;
    high_bound = CONT_HI;
    four_byte  = 1'b0;
    if (b <= 8'h7F) begin
      count_point();
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      conts_left = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      conts_left = 2'd2;
      // overlong three-byte forms and surrogates
      if (b == 8'hE0) begin
        low_bound = 8'hA0;
      end else if (b == 8'hED) begin
        high_bound = 8'h9F;
      end
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      conts_left = 2'd3;
      four_byte  = 1'b1;
      // overlong four-byte forms and code points above U+10FFFF
      if (b == 8'hF0) begin
        low_bound = 8'h90;
      end else if (b == 8'hF4) begin
        high_bound = 8'h8F;
      end
    end else begin
      bad_string = 1'b1;
    end
  endtask

  // Track transfers on both channels
  always @(posedge clk) begin
    result_t exp_rep;
    result_t got_rep;
    if (!rst_n) begin
      clear_scan();
      string_reports.delete();
      mismatch_total <= 0;
    end else begin
      // Check a report leaving the block against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got_rep.malformed   = out_mon.malformed;
        got_rep.code_points = out_mon.code_points;
        got_rep.utf16_units = out_mon.utf16_units;
        if (string_reports.size() == 0) begin
          if (mismatch_total < 10) begin
            $display("unexpected report: malformed=%0d points=%0d units=%0d",
                     got_rep.malformed, got_rep.code_points, got_rep.utf16_units);
          end
          mismatch_total <= mismatch_total + 1;
        end else begin
          exp_rep = string_reports.pop_front();
          if (got_rep.malformed !== exp_rep.malformed ||
              got_rep.code_points !== exp_rep.code_points ||
              got_rep.utf16_units !== exp_rep.utf16_units) begin
            if (mismatch_total < 10) begin
              $display("report mismatch: exp malformed=%0d points=%0d units=%0d",
                       exp_rep.malformed, exp_rep.code_points, exp_rep.utf16_units);
              $display("                 got malformed=%0d points=%0d units=%0d",
                       got_rep.malformed, got_rep.code_points, got_rep.utf16_units);
            end
            mismatch_total <= mismatch_total + 1;
          end
        end
      end
      // Scan accepted bytes, close the string on an end item
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_DATA) begin
          scan_byte(in_mon.data_byte);
        end else begin
          if (bad_string || conts_left != 2'd0) begin
            exp_rep.malformed   = 1'b1;
            exp_rep.code_points = '0;
            exp_rep.utf16_units = '0;
          end else begin
            exp_rep.malformed   = 1'b0;
            exp_rep.code_points = point_total;
            exp_rep.utf16_units = unit_total;
          end
          string_reports = {string_reports, exp_rep};
          clear_scan();
        end
      end
    end
    reports_due <= string_reports.size();
  end

endmodule

`default_nettype wire

// File: tb/utf8_validate_and_count_tb.sv
// ----------------------------------------------------------------------------
// UTF-8 validator testbench
// Sends directed and random byte strings, each closed by an end item, under
// three backpressure profiles; the scoreboard checks every report.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_validate_and_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8vc_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   items_sent;
  int   mismatch_total;
  int   reports_due;

  u8vc_in_if  in_ch ();
  u8vc_out_if out_ch ();

  utf8_validate_and_count dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf8_validate_and_count_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_total (mismatch_total),
    .reports_due    (reports_due)
  );

  always #5 clk = ~clk;

  // Receiver: stall at random according to the current profile
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Pick a byte in [lo, hi], with the bounds themselves favored
  function automatic logic [7:0] pick_byte(input logic [7:0] lo, input logic [7:0] hi);
    int unsigned r;
    r = $urandom_range(3);
    if (r == 0) begin
      return lo;
    end
    if (r == 1) begin
      return hi;
    end
    return 8'($urandom_range(hi, lo));
  endfunction

  // Present one item, holding it until the transfer; valid stays high on return
  task automatic send_item(input logic kind, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Send the bytes of one string, then its end item with a junk byte
  task automatic send_string(input logic [7:0] bytes[$]);
    foreach (bytes[i]) begin
      send_item(KIND_DATA, bytes[i]);
    end
    send_item(KIND_END, 8'($urandom_range(255)));
  endtask

  // Hold the sender off until every report has come back
  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    logic [7:0]  str[$];
    logic [7:0]  lead;
    int          base;
    int          n_points;
    int unsigned r;
    int unsigned idx;

    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_DATA;
    in_ch.data_byte <= 8'h00;
    rst_n           <= 1'b0;
    src_idle_pct  = 10;
    sink_idle_pct = 68;
    items_sent    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty string
    send_item(KIND_END, 8'hFF);
    // Widest well-formed values of each length: 4 points, 5 units
    send_string('{8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                  8'hF4, 8'h8F, 8'hBF, 8'hBF});
    // Stray continuation, later bytes ignored
    send_string('{8'h80, 8'h41});
    // Surrogate
    send_string('{8'hED, 8'hA0, 8'h80});
    // Truncated sequence at the end
    send_string('{8'hF0});
    // Invalid lead byte
    send_string('{8'hFF});
    // Overlong three-byte form
    send_string('{8'hE0, 8'h9F});
    drain_reports();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 10;
          sink_idle_pct = 68;
        end
        1: begin
          src_idle_pct  = 68;
          sink_idle_pct = 10;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      base = items_sent;
      while (items_sent < base + 200) begin
        // Build a well-formed string with random content
        str.delete();
        n_points = $urandom_range(6);
        repeat (n_points) begin
          case ($urandom_range(3))
            0: str = {str, pick_byte(8'h00, 8'h7F)};
            1: begin
              str = {str, pick_byte(8'hC2, 8'hDF)};
              str = {str, pick_byte(CONT_LO, CONT_HI)};
            end
            2: begin
              lead = pick_byte(8'hE0, 8'hEF);
              str = {str, lead};
              str = {str, pick_byte((lead == 8'hE0) ? 8'hA0 : CONT_LO,
                                    (lead == 8'hED) ? 8'h9F : CONT_HI)};
              str = {str, pick_byte(CONT_LO, CONT_HI)};
            end
            default: begin
              lead = pick_byte(8'hF0, 8'hF4);
              str = {str, lead};
              str = {str, pick_byte((lead == 8'hF0) ? 8'h90 : CONT_LO,
                                    (lead == 8'hF4) ? 8'h8F : CONT_HI)};
              str = {str, pick_byte(CONT_LO, CONT_HI)};
              str = {str, pick_byte(CONT_LO, CONT_HI)};
            end
          endcase
        end
        // Damage some strings, replace a few by pure noise
        r = $urandom_range(99);
        if (r < 12) begin
          str.delete();
          repeat ($urandom_range(6)) str = {str, 8'($urandom_range(255))};
        end else if (r < 20 && str.size() > 0) begin
          idx = $urandom_range(str.size() - 1);
          str[idx] = 8'($urandom_range(255));
        end else if (r < 26 && str.size() > 0) begin
          void'(str.pop_back());
        end else if (r < 30) begin
          idx = $urandom_range(str.size());
          str.insert(idx, 8'($urandom_range(255)));
        end
        send_string(str);
      end
      drain_reports();
    end

    // Let any late report surface before the verdict
    repeat (20) @(posedge clk);
    if (mismatch_total == 0 && reports_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/u8vc_pkg.sv
hw/rtl/u8vc_if.sv
hw/rtl/u8vc_lead_decode.sv
hw/rtl/u8vc_scan.sv
hw/rtl/utf8_validate_and_count.sv
tb/utf8_validate_and_count_checker.sv
tb/utf8_validate_and_count_tb.sv
